// ===== hw/rtl/tpf_pkg.sv =====
// Shared types and constants for the threshold pulse finder.
// No dependencies; every other file of the block uses this package.
package tpf_pkg;

    // Fixed field widths.
    localparam int SMP_W  = 12;
    localparam int IDX_W  = 12;
    localparam int CHG_W  = 25;
    localparam int DIFF_W = SMP_W + 1;
    localparam int CFG_W  = 12;

    // Configuration register indexes.
    localparam logic [0:0] CFG_THRESHOLD = 1'b0;
    localparam logic [0:0] CFG_BASELINE  = 1'b1;

    // Register reset values.
    localparam logic signed [SMP_W-1:0] THRESHOLD_RST = -12'sd40;
    localparam logic signed [SMP_W-1:0] BASELINE_RST  = 12'sd0;

    // Saturation limits of the running charge sum.
    localparam logic [CHG_W-1:0] CHG_MAX = {1'b0, {(CHG_W-1){1'b1}}};
    localparam logic [CHG_W-1:0] CHG_MIN = {1'b1, {(CHG_W-1){1'b0}}};

    // One classified sample as it travels from the front end to the back end.
    typedef struct packed {
        logic [SMP_W-1:0]  sample;
        logic [DIFF_W-1:0] diff;
        logic [IDX_W-1:0]  idx;
        logic              below;
        logic              above;
        logic              last;
    } t_item;

    // Queue status seen by both ends.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== hw/rtl/tpf_if.sv =====
// Handshake interfaces for the sample request and result request channels.
// Depends on tpf_pkg for the field widths.
interface tpf_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [tpf_pkg::SMP_W-1:0]  sample;
    logic                              last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface tpf_out_if;
    logic                              valid;
    logic                              ready;
    logic [tpf_pkg::IDX_W-1:0]         start_index;
    logic [tpf_pkg::IDX_W-1:0]         peak_index;
    logic signed [tpf_pkg::SMP_W-1:0]  peak_value;
    logic signed [tpf_pkg::CHG_W-1:0]  charge;

    modport source (output valid, output start_index, output peak_index,
                    output peak_value, output charge, input ready);
    modport sink   (input valid, input start_index, input peak_index,
                    input peak_value, input charge, output ready);
endinterface

// ===== hw/rtl/tpf_front.sv =====
// Front end: accepts samples, numbers them and classifies them against the threshold.
// Depends on tpf_pkg and tpf_in_if.
module tpf_front #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tpf_in_if.sink                            i_smp,
    input  logic signed [tpf_pkg::SMP_W-1:0]  i_threshold,
    input  logic signed [tpf_pkg::SMP_W-1:0]  i_baseline,
    input  tpf_pkg::t_q_stat                  i_q_stat,
    output logic                              o_push,
    output tpf_pkg::t_item                    o_item
);
    import tpf_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_SAMPLES - 1);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [IDX_W-1:0] w_idx;

    // The queue takes a request whenever it has room.
    assign i_smp.ready = !i_q_stat.full;
    assign o_push      = i_smp.valid && !i_q_stat.full;

    // Sample index as reported on the result fields.
    generate
        if (CNT_W >= IDX_W) begin : g_idx_trunc
            assign w_idx = r_cnt[IDX_W-1:0];
        end else begin : g_idx_ext
            assign w_idx = {{(IDX_W-CNT_W){1'b0}}, r_cnt};
        end
    endgenerate

    // Classification and pedestal correction of the incoming sample.
    always_comb begin
        o_item.sample = i_smp.sample;
        o_item.diff   = {i_smp.sample[SMP_W-1], i_smp.sample}
                      - {i_baseline[SMP_W-1], i_baseline};
        o_item.idx    = w_idx;
        o_item.below  = i_smp.sample < i_threshold;
        o_item.above  = i_smp.sample > i_threshold;
        o_item.last   = i_smp.last_sample;
    end

    // Sample counter wraps after MAX_SAMPLES samples and restarts after the last sample.
    always_comb begin
        n_cnt = r_cnt;
        if (o_push) begin
            if (i_smp.last_sample || r_cnt == CNT_LAST) begin
                n_cnt = '0;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== hw/rtl/tpf_fifo.sv =====
// Two-entry queue between the front end and the back end.
// Depends on tpf_pkg for the item and status types.
module tpf_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tpf_pkg::t_item    i_item,
    input  logic              i_pop,
    output tpf_pkg::t_item    o_item,
    output tpf_pkg::t_q_stat  o_stat
);
    import tpf_pkg::*;

    t_item      r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_item       = r_mem[r_rd];
    assign o_stat.full  = r_cnt == 2'd2;
    assign o_stat.empty = r_cnt == 2'd0;

    // Occupancy follows pushes and pops.
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== hw/rtl/tpf_back.sv =====
// Back end: pulse tracking, peak search, saturating charge sum and result register.
// Depends on tpf_pkg and tpf_out_if.
module tpf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tpf_pkg::t_q_stat  i_q_stat,
    input  tpf_pkg::t_item    i_item,
    output logic              o_pop,
    tpf_out_if.source         o_res
);
    import tpf_pkg::*;

    logic                     r_in_pulse;
    logic                     n_in_pulse;
    logic [IDX_W-1:0]         r_start;
    logic signed [SMP_W-1:0]  r_min;
    logic [IDX_W-1:0]         r_min_idx;
    logic [CHG_W-1:0]         r_sum;

    logic                     r_out_valid;
    logic [IDX_W-1:0]         r_out_start;
    logic [IDX_W-1:0]         r_out_peak_idx;
    logic signed [SMP_W-1:0]  r_out_peak;
    logic [CHG_W-1:0]         r_out_charge;

    logic                     w_open;
    logic                     w_act;
    logic                     w_close;
    logic signed [SMP_W-1:0]  w_smp;
    logic signed [SMP_W-1:0]  w_cur_min;
    logic [IDX_W-1:0]         w_cur_min_idx;
    logic [IDX_W-1:0]         w_cur_start;
    logic [CHG_W-1:0]         w_cur_sum;
    logic signed [SMP_W-1:0]  w_new_min;
    logic [IDX_W-1:0]         w_new_min_idx;
    logic [CHG_W:0]           w_sum_wide;
    logic [CHG_W-1:0]         w_new_sum;

    // Take the next request when the result register is free or being drained.
    assign o_pop = !i_q_stat.empty && (!r_out_valid || o_res.ready);

    // One sample step of the discriminator.
    always_comb begin
        w_smp         = $signed(i_item.sample);
        w_open        = !r_in_pulse && i_item.below;
        w_act         = r_in_pulse || w_open;
        w_close       = w_act && i_item.above;
        w_cur_min     = w_open ? '0 : r_min;
        w_cur_min_idx = w_open ? i_item.idx : r_min_idx;
        w_cur_start   = w_open ? i_item.idx : r_start;
        w_cur_sum     = w_open ? '0 : r_sum;

        // Peak moves only on a strictly lower sample, so ties keep the earliest.
        if (w_smp < w_cur_min) begin
            w_new_min     = w_smp;
            w_new_min_idx = i_item.idx;
        end else begin
            w_new_min     = w_cur_min;
            w_new_min_idx = w_cur_min_idx;
        end

        // Saturating accumulation: overflow shows as differing top two bits.
        w_sum_wide = {w_cur_sum[CHG_W-1], w_cur_sum}
                   + {{(CHG_W+1-DIFF_W){i_item.diff[DIFF_W-1]}}, i_item.diff};
        if (w_sum_wide[CHG_W] != w_sum_wide[CHG_W-1]) begin
            w_new_sum = w_sum_wide[CHG_W] ? CHG_MIN : CHG_MAX;
        end else begin
            w_new_sum = w_sum_wide[CHG_W-1:0];
        end

        // A pulse stays open until it closes or the waveform ends.
        n_in_pulse = r_in_pulse;
        if (o_pop) begin
            n_in_pulse = w_act && !i_item.above && !i_item.last;
        end
    end

    // Pulse tracking state; only the open flag needs a reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_pulse <= 1'b0;
        end else begin
            r_in_pulse <= n_in_pulse;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_act) begin
            r_start   <= w_cur_start;
            r_min     <= w_new_min;
            r_min_idx <= w_new_min_idx;
            r_sum     <= w_new_sum;
        end
    end

    // Result register toward the output channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && w_close) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_close) begin
            r_out_start    <= w_cur_start;
            r_out_peak_idx <= w_new_min_idx;
            r_out_peak     <= w_new_min;
            r_out_charge   <= w_new_sum;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.start_index = r_out_start;
    assign o_res.peak_index  = r_out_peak_idx;
    assign o_res.peak_value  = r_out_peak;
    assign o_res.charge      = $signed(r_out_charge);

endmodule

// ===== hw/rtl/threshold_pulse_finder_top.sv =====
// Threshold pulse finder: an accepted sample goes through the queue, and its result through the result register;
// throughput is one sample per cycle, set by the back end's one-step accumulator, unless results stall.
// The two-entry queue lets the front end keep taking samples while a result waits.
// Reset (synchronous, active low) sets threshold to -40 and baseline to 0, clears the sample
// counter, empties the queue, closes any open pulse and drops a pending result.
// Depends on tpf_pkg, tpf_if, tpf_front, tpf_fifo and tpf_back.
module threshold_pulse_finder_top #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tpf_in_if.sink                         i_smp,
    tpf_out_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [0:0]                     i_cfg_index,
    input  logic [tpf_pkg::CFG_W-1:0]      i_cfg_data
);
    import tpf_pkg::*;

    logic signed [SMP_W-1:0] r_threshold;
    logic signed [SMP_W-1:0] r_baseline;

    logic     w_push;
    logic     w_pop;
    t_item    w_front_item;
    t_item    w_back_item;
    t_q_stat  w_q_stat;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_baseline  <= BASELINE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= $signed(i_cfg_data[SMP_W-1:0]);
                CFG_BASELINE:  r_baseline  <= $signed(i_cfg_data[SMP_W-1:0]);
                default:       r_threshold <= r_threshold;
            endcase
        end
    end

    tpf_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_smp       (i_smp),
        .i_threshold (r_threshold),
        .i_baseline  (r_baseline),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_item      (w_front_item)
    );

    tpf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_back_item),
        .o_stat  (w_q_stat)
    );

    tpf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_item   (w_back_item),
        .o_pop    (w_pop),
        .o_res    (o_res)
    );

    // The back end never takes from an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("pop from empty queue");

    // A drained result with no new sample behind it leaves the output empty.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && !w_pop) |=> !o_res.valid)
        else $error("result repeated after being taken");

    // The reported peak is never above zero.
    a_peak_nonpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.peak_value[SMP_W-1] || o_res.peak_value == '0))
        else $error("positive peak value reported");

    // A full queue, the only reason to refuse a sample, stays full until the back end pops an entry.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_stat.full && !w_pop) |=> w_q_stat.full)
        else $error("queue lost an entry without a pop");

endmodule

// ===== tb/sv/threshold_pulse_finder_top_tb.sv =====
// Self-checking testbench for threshold_pulse_finder_top: drives sample requests, predicts
// every pulse in a local model of the finder and compares each result request field by field.
// Depends on tpf_pkg, tpf_if and the block's RTL.
module threshold_pulse_finder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpf_pkg::*;

    // One predicted pulse, at the widths of the result channel.
    typedef struct {
        logic [IDX_W-1:0]         start_idx;
        logic [IDX_W-1:0]         peak_idx;
        logic signed [SMP_W-1:0]  peak_val;
        logic signed [CHG_W-1:0]  charge;
    } t_pulse;

    localparam int CHG_HI = 16777215;
    localparam int CHG_LO = -16777216;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [0:0]           cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    tpf_in_if  smp_if ();
    tpf_out_if res_if ();

    threshold_pulse_finder_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_smp       (smp_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Local copy of the finder: levels and pulse tracking state.
    logic signed [SMP_W-1:0] lvl_thr;
    logic signed [SMP_W-1:0] lvl_base;
    logic                    pf_open;
    logic [IDX_W-1:0]        pf_count;
    logic [IDX_W-1:0]        pf_start;
    logic signed [SMP_W-1:0] pf_min;
    logic [IDX_W-1:0]        pf_min_idx;
    logic signed [CHG_W-1:0] pf_sum;

    t_pulse pending_pulses[$];
    int     mismatch_count = 0;
    bit     idle_en = 1'b1;
    int     hold_req = 0;

    // Clear the pulse tracking state, as the finder does after the last sample.
    task automatic clear_tracking();
        pf_open    = 1'b0;
        pf_count   = '0;
        pf_start   = '0;
        pf_min     = '0;
        pf_min_idx = '0;
        pf_sum     = '0;
    endtask

    // Advance the local finder by one accepted sample and queue any pulse it closes.
    task automatic predict_pulse(input logic signed [SMP_W-1:0] s, input logic last);
        logic [IDX_W-1:0] idx;
        int               acc;
        t_pulse           p;
        idx = pf_count;
        if (!pf_open && s < lvl_thr) begin
            pf_open    = 1'b1;
            pf_start   = idx;
            pf_min     = '0;
            pf_min_idx = idx;
            pf_sum     = '0;
        end
        if (pf_open) begin
            if (s < pf_min) begin
                pf_min     = s;
                pf_min_idx = idx;
            end
            acc = int'(pf_sum) + int'(s) - int'(lvl_base);
            if (acc > CHG_HI) acc = CHG_HI;
            if (acc < CHG_LO) acc = CHG_LO;
            pf_sum = acc[CHG_W-1:0];
            if (s > lvl_thr) begin
                p.start_idx = pf_start;
                p.peak_idx  = pf_min_idx;
                p.peak_val  = pf_min;
                p.charge    = pf_sum;
                pending_pulses.insert(pending_pulses.size(), p);
                pf_open = 1'b0;
                pf_min  = '0;
                pf_sum  = '0;
            end
        end
        pf_count = pf_count + 1'b1;
        if (last) clear_tracking();
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    function automatic logic signed [SMP_W-1:0] clamp_smp(input int v);
        if (v > 2047) return 12'sd2047;
        if (v < -2048) return -12'sd2048;
        return v[SMP_W-1:0];
    endfunction

    // Offer one sample request and wait until the finder takes it.
    task automatic send_sample(input logic signed [SMP_W-1:0] s, input logic last);
        int gap;
        @(negedge i_clk);
        if (idle_en && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 15);
            smp_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        smp_if.valid       <= 1'b1;
        smp_if.sample      <= s;
        smp_if.last_sample <= last;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        predict_pulse(s, last);
    endtask

    task automatic end_stream();
        @(negedge i_clk);
        smp_if.valid <= 1'b0;
    endtask

    // Wait until every predicted pulse has come out, then let the pipeline drain.
    task automatic wait_idle();
        while (pending_pulses.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic signed [SMP_W-1:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_THRESHOLD) lvl_thr = val;
        else lvl_base = val;
    endtask

    // Change both levels once the finder has gone quiet.
    task automatic set_levels(input int thr, input int base);
        end_stream();
        wait_idle();
        write_reg(CFG_THRESHOLD, clamp_smp(thr));
        write_reg(CFG_BASELINE, clamp_smp(base));
    endtask

    // One waveform of quiet stretches and dips below the threshold, with some noise.
    task automatic send_random_waveform(output int n);
        int len;
        int r;
        int v;
        bit in_dip;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 600) : $urandom_range(4, 64);
        in_dip = $urandom_range(0, 3) == 0;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                v = $signed($urandom_range(0, 4095)) - 2048;
            end else if (in_dip) begin
                v = (r < 14) ? int'(lvl_thr) : int'(lvl_thr) - int'($urandom_range(1, 400));
                if ($urandom_range(0, 4) == 0) in_dip = 1'b0;
            end else begin
                v = (r < 14) ? int'(lvl_thr) : int'(lvl_thr) + int'($urandom_range(1, 200));
                if ($urandom_range(0, 5) == 0) in_dip = 1'b1;
            end
            send_sample(clamp_smp(v), i == len - 1);
        end
        n = len;
    endtask

    // Reset levels: equal samples, earliest peak on a tie, closing and dropping on the last sample.
    task automatic test_reset_levels();
        send_sample(-12'sd40, 1'b0);
        send_sample(-12'sd41, 1'b0);
        send_sample(-12'sd2048, 1'b0);
        send_sample(-12'sd40, 1'b0);
        send_sample(12'sd2047, 1'b0);
        send_sample(-12'sd2048, 1'b0);
        send_sample(-12'sd2048, 1'b0);
        send_sample(12'sd0, 1'b0);
        send_sample(-12'sd100, 1'b0);
        send_sample(-12'sd50, 1'b1);
        send_sample(-12'sd41, 1'b0);
        send_sample(12'sd100, 1'b1);
        end_stream();
    endtask

    // Extreme levels and the peak that stays at zero.
    task automatic test_level_extremes();
        set_levels(2047, -2048);
        send_sample(12'sd2046, 1'b0);
        send_sample(12'sd2047, 1'b0);
        send_sample(-12'sd2048, 1'b1);
        set_levels(-2048, 2047);
        send_sample(-12'sd2048, 1'b0);
        send_sample(12'sd2047, 1'b1);
        set_levels(10, 5);
        send_sample(12'sd3, 1'b0);
        send_sample(12'sd10, 1'b0);
        send_sample(12'sd11, 1'b0);
        send_sample(12'sd0, 1'b0);
        send_sample(12'sd2047, 1'b1);
        end_stream();
    endtask

    // Long pulses that build large charges in both directions.
    task automatic test_long_pulses();
        set_levels(-2047, 2047);
        for (int i = 0; i < 5; i++) send_sample(12'sd0, 1'b0);
        for (int i = 0; i < 90; i++) send_sample(-12'sd2048, 1'b0);
        send_sample(12'sd0, 1'b0);
        send_sample(-12'sd2048, 1'b0);
        send_sample(12'sd0, 1'b0);
        send_sample(12'sd0, 1'b1);
        set_levels(2046, -2048);
        for (int i = 0; i < 90; i++) send_sample(12'sd2045, 1'b0);
        send_sample(12'sd2047, 1'b1);
        end_stream();
    endtask

    // Hold the result side off while short pulses keep coming, so the input stalls.
    task automatic test_backpressure();
        bit saved;
        set_levels(-40, 0);
        saved = idle_en;
        idle_en = 1'b0;
        hold_req = 300;
        for (int i = 0; i < 60; i++) begin
            send_sample(-12'sd1000, 1'b0);
            send_sample(12'sd500, i == 59);
        end
        end_stream();
        idle_en = saved;
    endtask

    // Random waveforms under a sequence of level settings; the last phase runs without idling.
    task automatic test_random_waveforms();
        int thr_set[7]  = '{-40, -300, 0, -2048, 2047, -1500, -60};
        int base_set[7] = '{0, -50, 0, 2047, -2048, 1000, 10};
        int sent;
        int n;
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7) begin
                set_levels(-60, 10);
                idle_en = 1'b0;
            end else if (ph == 6) begin
                set_levels($signed($urandom_range(0, 4095)) - 2048,
                           $signed($urandom_range(0, 4095)) - 2048);
            end else begin
                set_levels(thr_set[ph], base_set[ph]);
            end
            sent = 0;
            while (sent < ((ph == 7) ? 90 : 80)) begin
                send_random_waveform(n);
                sent += n;
            end
        end
        end_stream();
    endtask

    // Result side: random stall bursts, plus a long hold when a test asks for one.
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else if (idle_en && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result request with the oldest predicted pulse.
    always @(posedge i_clk) begin
        t_pulse p;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_pulses.size() == 0) begin
                report_mismatch("result request with no pulse predicted");
            end else begin
                p = pending_pulses.pop_front();
                if (res_if.start_index !== p.start_idx)
                    report_mismatch($sformatf("start_index got %0d expected %0d",
                                              res_if.start_index, p.start_idx));
                if (res_if.peak_index !== p.peak_idx)
                    report_mismatch($sformatf("peak_index got %0d expected %0d",
                                              res_if.peak_index, p.peak_idx));
                if (res_if.peak_value !== p.peak_val)
                    report_mismatch($sformatf("peak_value got %0d expected %0d",
                                              res_if.peak_value, p.peak_val));
                if (res_if.charge !== p.charge)
                    report_mismatch($sformatf("charge got %0d expected %0d",
                                              res_if.charge, p.charge));
            end
        end
    end

    // Run limit.
    initial begin
        #2000000;
        $display("** threshold_pulse_finder_top: FAILED **");
        $finish;
    end

    // Test sequence.
    initial begin
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_THRESHOLD;
        cfg_data           = '0;
        smp_if.valid       = 1'b0;
        smp_if.sample      = '0;
        smp_if.last_sample = 1'b0;
        lvl_thr            = THRESHOLD_RST;
        lvl_base           = BASELINE_RST;
        clear_tracking();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_levels();
        test_level_extremes();
        test_long_pulses();
        test_backpressure();
        test_random_waveforms();

        wait_idle();
        if (mismatch_count == 0 && pending_pulses.size() == 0) begin
            $display("** threshold_pulse_finder_top: PASSED **");
        end else begin
            $display("** threshold_pulse_finder_top: FAILED **");
        end
        $finish;
    end

endmodule
